// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- hdl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Address resolution table package
// Item types, field widths, action codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  localparam int PROTO_W = 32;
  localparam int HW_W    = 48;
  localparam int SLOT_W  = 2;

  // Action codes carried in the request item.
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_ADD    = 1'b1;

  typedef struct packed {
    logic               action;
    logic [PROTO_W-1:0] proto_addr;
    logic [HW_W-1:0]    hw_addr;
  } req_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [HW_W-1:0]   hw_out;
    logic              evicted;
  } rsp_item_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_CMP    = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESP   = 5'b10000
  } seq_state_t;

endpackage

`default_nettype wire

// ----- hdl/arp_cache_fifo_table_core.sv -----
// ----------------------------------------------------------------------------
// Address resolution table core
// Fully associative protocol-to-hardware address table with first-in
// first-out replacement, searched one entry at a time by a shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries a lookup or an add
//   item; response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   result item per request, in order.
//   The table is searched oldest entry first through a single memory read
//   port and one 32-bit comparator: each entry scanned takes a read step and
//   a compare step. The scan stops at the first match or after the last valid
//   entry, and an empty table is not scanned; an update step then forms the
//   result, the response step loads it into the output register, and the
//   sequencer returns to idle before it takes the next request. req_stall is
//   high while an item is in progress.
//   The output register parts the two sides: a new request is accepted while
//   the previous result still waits. If the receiver stalls and the output
//   register is still full when the next result is ready, the sequencer holds
//   in its response step until the register drains.
//   Reset empties the table at once: a fill count marks valid entries and a
//   head pointer marks the oldest one, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_fifo_table_core #(
  parameter int ENTRIES = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_stall,
  input  arpc_pkg::req_item_t  req,
  output logic                 rsp_valid,
  input  wire                  rsp_stall,
  output arpc_pkg::rsp_item_t  rsp
);

  import arpc_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // Entry storage: ring buffer, logical slot i lives at (head + i) mod ENTRIES.
  logic [PROTO_W-1:0] mem_proto [ENTRIES];
  logic [HW_W-1:0]    mem_hw    [ENTRIES];
  logic [PROTO_W-1:0] rd_proto;
  logic [HW_W-1:0]    rd_hw;

  seq_state_t  state, state_next;
  req_item_t   item;
  rsp_item_t   res;
  logic [IW-1:0] idx;
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic          found;

  logic          full;
  logic          match;
  logic          last;
  logic [IW:0]   phys_sum;
  logic [IW-1:0] phys;
  logic          we;
  logic [IW-1:0] waddr;
  logic          rsp_load;

  // Address of the entry at logical position idx.
  always_comb begin
    phys_sum = (IW + 1)'(head) + (IW + 1)'(idx);
    if (phys_sum >= (IW + 1)'(ENTRIES)) begin
      phys = IW'(phys_sum - (IW + 1)'(ENTRIES));
    end else begin
      phys = IW'(phys_sum);
    end
  end

  assign full  = (count == CW'(ENTRIES));
  assign match = (rd_proto == item.proto_addr);
  assign last  = ((CW'(idx) + CW'(1)) == count);

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_RESP) && (!rsp_valid || !rsp_stall);

  // Table write at the update step of an add item.
  always_comb begin
    we = (state == S_UPDATE) && (item.action == ACT_ADD);
    if (found) begin
      waddr = phys;
    end else if (full) begin
      waddr = head;
    end else begin
      waddr = count[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_proto[waddr] <= item.proto_addr;
      mem_hw[waddr]    <= item.hw_addr;
    end
  end

  // Registered read port, one entry per scan step.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_proto <= mem_proto[phys];
      rd_hw    <= mem_hw[phys];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (count == '0) ? S_UPDATE : S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (match || last) begin
          state_next = S_UPDATE;
        end else begin
          state_next = S_READ;
        end
      end
      S_UPDATE: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture, scan index and match flag.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      item  <= req;
      idx   <= '0;
      found <= 1'b0;
    end else if (state == S_CMP) begin
      if (match) begin
        found <= 1'b1;
      end else if (!last) begin
        idx <= idx + IW'(1);
      end
    end
  end

  // Fill count and oldest-entry pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else if (we && !found) begin
      if (full) begin
        if (head == IW'(ENTRIES - 1)) begin
          head <= '0;
        end else begin
          head <= head + IW'(1);
        end
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  // Result formation at the update step.
  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      res.evicted <= 1'b0;
      if (item.action == ACT_LOOKUP) begin
        res.hit    <= found;
        res.slot   <= found ? SLOT_W'(idx) : '0;
        res.hw_out <= found ? rd_hw : '0;
      end else if (found) begin
        res.hit    <= 1'b1;
        res.slot   <= SLOT_W'(idx);
        res.hw_out <= item.hw_addr;
      end else if (full) begin
        res.hit     <= 1'b0;
        res.slot    <= SLOT_W'(ENTRIES - 1);
        res.hw_out  <= item.hw_addr;
        res.evicted <= 1'b1;
      end else begin
        res.hit    <= 1'b0;
        res.slot   <= SLOT_W'(count);
        res.hw_out <= item.hw_addr;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  // Checks on table bookkeeping and sequencing.
  `ASSERT_CLK(a_count_range, clk, rst, count <= CW'(ENTRIES))
  `ASSERT_CLK(a_head_only_when_full, clk, rst, (head != '0) |-> full)
  `ASSERT_CLK(a_scan_in_range, clk, rst, (state == S_CMP) |-> (CW'(idx) < count))
  `ASSERT_CLK(a_accept_starts, clk, rst,
              (req_valid && !req_stall) |=> (state == S_READ || state == S_UPDATE))
  `ASSERT_CLK(a_rsp_from_seq, clk, rst, $rose(rsp_valid) |-> $past(state == S_RESP))

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address resolution table testbench
// Drives lookup and add items into the table core and checks every result
// against a cycle-free software copy of the four-slot table. A short directed
// run covers empty lookups, address extremes, updates, filling and eviction.
// A long random run then draws addresses from a small shifting pool so that
// hits, updates and evictions stay frequent.
// ----------------------------------------------------------------------------

module tb_top;
  import arpc_pkg::*;

  localparam int ENTRIES      = 4;
  localparam int RANDOM_ITEMS = 1630;
  localparam int ADDR_POOL    = 7;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  // Idle percentages per phase: sender light / receiver heavy, then swapped,
  // then none.
  localparam int SEND_IDLE[3]  = '{34, 84, 0};
  localparam int RECV_STALL[3] = '{84, 34, 0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_item_t   req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_item_t   rsp;

  // Software copy of the table.
  logic [PROTO_W-1:0] shadow_proto [ENTRIES];
  logic [HW_W-1:0]    shadow_hw    [ENTRIES];
  logic               shadow_valid [ENTRIES];

  req_item_t arp_requests[$];
  rsp_item_t expected_answers[$];
  rsp_item_t answer_due;

  int  total_items;
  int  accepted_items = 0;
  int  phase;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  timed_out = 1'b0;

  arp_cache_fifo_table_core #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  always_comb begin
    phase = (total_items > 0) ? (accepted_items * 3) / total_items : 0;
    if (phase > 2) phase = 2;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_request(input logic act, input logic [PROTO_W-1:0] addr,
                               input logic [HW_W-1:0] hw);
    req_item_t r;
    r.action     = act;
    r.proto_addr = addr;
    r.hw_addr    = hw;
    arp_requests.push_back(r);
  endtask

  // Applies one item to the software table and returns the answer it yields.
  function automatic rsp_item_t resolve_entry(req_item_t r);
    rsp_item_t a;
    int        i;
    int        match;
    int        free_slot;
    a = '0;
    match = -1;
    free_slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (match < 0 && shadow_valid[i] && shadow_proto[i] == r.proto_addr) match = i;
    end
    if (r.action == ACT_LOOKUP) begin
      if (match >= 0) begin
        a.hit    = 1'b1;
        a.slot   = match[SLOT_W-1:0];
        a.hw_out = shadow_hw[match];
      end
    end else if (match >= 0) begin
      shadow_hw[match] = r.hw_addr;
      a.hit    = 1'b1;
      a.slot   = match[SLOT_W-1:0];
      a.hw_out = r.hw_addr;
    end else begin
      for (i = 0; i < ENTRIES; i++) begin
        if (free_slot < 0 && !shadow_valid[i]) free_slot = i;
      end
      // Full table: drop the oldest entry and append at the top.
      if (free_slot < 0) begin
        for (i = 1; i < ENTRIES; i++) begin
          shadow_proto[i-1] = shadow_proto[i];
          shadow_hw[i-1]    = shadow_hw[i];
          shadow_valid[i-1] = shadow_valid[i];
        end
        free_slot = ENTRIES - 1;
        a.evicted = 1'b1;
      end
      shadow_proto[free_slot] = r.proto_addr;
      shadow_hw[free_slot]    = r.hw_addr;
      shadow_valid[free_slot] = 1'b1;
      a.slot   = free_slot[SLOT_W-1:0];
      a.hw_out = r.hw_addr;
    end
    return a;
  endfunction

  // Request driver: predicts each accepted item, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_answers.push_back(resolve_entry(req));
        accepted_items++;
      end
      if (!req_valid || !req_stall) begin
        if (arp_requests.size() > 0 && $urandom_range(99) >= SEND_IDLE[phase]) begin
          req       <= arp_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each accepted result with the oldest answer due.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_answers.size() == 0) begin
          flag_mismatch("result arrived with no request outstanding");
        end else begin
          answer_due = expected_answers.pop_front();
          if (rsp.hit !== answer_due.hit)
            flag_mismatch($sformatf("hit got %b want %b", rsp.hit, answer_due.hit));
          if (rsp.slot !== answer_due.slot)
            flag_mismatch($sformatf("slot got %0d want %0d", rsp.slot, answer_due.slot));
          if (rsp.hw_out !== answer_due.hw_out)
            flag_mismatch($sformatf("hw_out got %h want %h", rsp.hw_out,
                                    answer_due.hw_out));
          if (rsp.evicted !== answer_due.evicted)
            flag_mismatch($sformatf("evicted got %b want %b", rsp.evicted,
                                    answer_due.evicted));
        end
      end
      rsp_stall <= ($urandom_range(99) < RECV_STALL[phase]);
    end
  end

  // Watchdog: a long stretch with no item moving on either side ends the run.
  always @(posedge clk) begin
    if (!rst && !timed_out) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        flag_mismatch("no item moved within the watchdog limit");
        timed_out = 1'b1;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [PROTO_W-1:0] addr_pool [ADDR_POOL];
    logic [PROTO_W-1:0] addr;
    logic [HW_W-1:0]    hw;
    logic               act;
    int                 k;

    for (k = 0; k < ENTRIES; k++) begin
      shadow_proto[k] = '0;
      shadow_hw[k]    = '0;
      shadow_valid[k] = 1'b0;
    end

    // Directed part: empty table, extremes, update, fill, eviction.
    queue_request(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_request(ACT_ADD,    32'h0000_0000, 48'h0);
    queue_request(ACT_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_request(ACT_ADD,    32'h0000_0000, 48'h1234_5678_9ABC);
    queue_request(ACT_ADD,    32'hA5A5_A5A5, 48'hA5A5_A5A5_A5A5);
    queue_request(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    queue_request(ACT_ADD,    32'h5A5A_5A5A, 48'h5A5A_5A5A_5A5A);
    queue_request(ACT_LOOKUP, 32'h5A5A_5A5A, 48'hFFFF_FFFF_FFFF);
    queue_request(ACT_ADD,    32'h1234_5678, 48'hFEDC_BA98_7654);
    queue_request(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    queue_request(ACT_LOOKUP, 32'h1234_5678, 48'h0);
    queue_request(ACT_ADD,    32'hFFFF_FFFF, 48'h0);
    queue_request(ACT_LOOKUP, 32'hA5A5_A5A5, 48'hFFFF_FFFF_FFFF);
    queue_request(ACT_ADD,    32'h8765_4321, 48'h0000_0000_0001);
    queue_request(ACT_ADD,    32'h0000_FFFF, 48'h8000_0000_0000);
    queue_request(ACT_ADD,    32'hFFFF_0000, 48'h7FFF_FFFF_FFFF);
    queue_request(ACT_ADD,    32'h0F0F_0F0F, 48'hFFFF_FFFF_FFFF);
    queue_request(ACT_LOOKUP, 32'h8765_4321, 48'h0);
    queue_request(ACT_LOOKUP, 32'h0000_FFFF, 48'h0);
    queue_request(ACT_LOOKUP, 32'hFFFF_0000, 48'h0);
    queue_request(ACT_LOOKUP, 32'h0F0F_0F0F, 48'h0);
    queue_request(ACT_LOOKUP, 32'h1234_5678, 48'h0);

    // Random part: a small address pool keeps hits and evictions common, and
    // pool members are replaced now and then so new addresses keep coming.
    for (k = 0; k < ADDR_POOL; k++) addr_pool[k] = $urandom;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(15) == 0) addr_pool[$urandom_range(ADDR_POOL-1)] = $urandom;
      if ($urandom_range(9) == 0) addr = $urandom;
      else addr = addr_pool[$urandom_range(ADDR_POOL-1)];
      act = 1'($urandom_range(1));
      case ($urandom_range(15))
        0:       hw = '0;
        1:       hw = '1;
        default: hw = HW_W'({$urandom, $urandom});
      endcase
      queue_request(act, addr, hw);
    end
    total_items = arp_requests.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out &&
           (arp_requests.size() > 0 || req_valid || expected_answers.size() > 0))
      @(posedge clk);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_answers.size() > 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_answers.size()));

    if (!timed_out && mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/arpc_pkg.sv
hdl/arp_cache_fifo_table_core.sv
tb/sv/tb_top.sv
